// File: hdl/nixie_tube_shift_driver_assert.svh
// Assertion macros used by the checker of the nixie tube shift driver.
`ifndef NIXIE_TUBE_SHIFT_DRIVER_ASSERT_SVH
`define NIXIE_TUBE_SHIFT_DRIVER_ASSERT_SVH

// Checked only outside reset.
`define NTSD_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("ntsd assertion failed");

// Checked on every edge, reset included.
`define NTSD_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("ntsd assertion failed");

`endif

// File: hdl/ntsd_pkg.sv
// Types, constants and digit helpers for the nixie tube shift driver.
package ntsd_pkg;

    localparam int WORD_BITS       = 64;
    localparam int TUBE_COUNT      = 6;
    localparam int DIGIT_COUNT     = 10;
    localparam int DOT_COUNT       = 4;
    localparam int BIT_IDX_W       = $clog2(WORD_BITS);
    localparam int QUEUE_DEPTH_DEF = 2;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [BIT_IDX_W-1:0] bit_idx_t;
    typedef logic [3:0]           digit_t;

    localparam logic REQ_TIME = 1'b0;
    localparam logic REQ_RAW  = 1'b1;
    localparam logic FMT_12H  = 1'b0;
    localparam logic FMT_24H  = 1'b1;

    localparam bit_idx_t BIT_IDX_MAX = bit_idx_t'(WORD_BITS - 1);

    // Cathode map per tube: word bit lit is BIT_IDX_MAX - entry.
    localparam bit_idx_t CATHODE_MAP [TUBE_COUNT][DIGIT_COUNT] = '{
        '{6'd7,  6'd6,  6'd5,  6'd4,  6'd3,  6'd2,  6'd1,  6'd0,  6'd15, 6'd14},
        '{6'd13, 6'd12, 6'd11, 6'd10, 6'd9,  6'd8,  6'd23, 6'd22, 6'd21, 6'd20},
        '{6'd17, 6'd16, 6'd31, 6'd30, 6'd29, 6'd28, 6'd27, 6'd26, 6'd25, 6'd24},
        '{6'd39, 6'd38, 6'd37, 6'd36, 6'd35, 6'd34, 6'd33, 6'd32, 6'd47, 6'd46},
        '{6'd43, 6'd42, 6'd41, 6'd40, 6'd55, 6'd54, 6'd53, 6'd52, 6'd51, 6'd50},
        '{6'd49, 6'd48, 6'd63, 6'd62, 6'd61, 6'd60, 6'd59, 6'd58, 6'd57, 6'd56}
    };

    // Separator dots, direct word bit positions.
    localparam bit_idx_t DOT_BITS [DOT_COUNT] = '{6'd18, 6'd19, 6'd44, 6'd45};

    localparam logic [4:0] HOURS_12 = 5'd12;
    localparam logic [4:0] HOURS_24 = 5'd24;

    typedef struct packed {
        logic       req_type;
        logic [4:0] hour_value;
        logic [5:0] minute_value;
        logic [5:0] second_value;
        logic [3:0] digit_hour_tens;
        logic [3:0] digit_hour_units;
        logic [3:0] digit_minute_tens;
        logic [3:0] digit_minute_units;
        logic [3:0] digit_second_tens;
        logic [3:0] digit_second_units;
        logic       dots_on;
    } in_item_t;

    typedef struct packed {
        logic serial_bit;
        logic last_bit;
    } out_item_t;

    typedef struct packed {
        digit_t tens;
        digit_t units;
    } digit_pair_t;

    // Tens/units of a value below 64: six threshold compares.
    function automatic digit_pair_t split_digits(input logic [5:0] v);
        digit_pair_t r;
        logic [5:0]  base;
        r.tens = '0;
        base   = '0;
        for (int i = 1; i <= 6; i++) begin
            if (v >= 6'(10 * i)) begin
                r.tens = digit_t'(i);
                base   = 6'(10 * i);
            end
        end
        r.units = digit_t'(v - base);
        return r;
    endfunction

    // 12-hour reduction: modulo 12, zero shown as 12.
    function automatic logic [4:0] hour_12(input logic [4:0] h);
        logic [4:0] r;
        if (h >= HOURS_24) begin
            r = h - HOURS_24;
        end else if (h >= HOURS_12) begin
            r = h - HOURS_12;
        end else begin
            r = h;
        end
        if (r == '0) begin
            r = HOURS_12;
        end
        return r;
    endfunction

    // One-hot cathode bit for a tube; blank for digits of 10 and up.
    function automatic word_t digit_mask(input logic [$clog2(TUBE_COUNT)-1:0] tube,
                                         input digit_t d);
        word_t m;
        m = '0;
        if (d < digit_t'(DIGIT_COUNT)) begin
            m[BIT_IDX_MAX - CATHODE_MAP[tube][d]] = 1'b1;
        end
        return m;
    endfunction

endpackage

// File: hdl/ntsd_front.sv
// Front end: register port, item decode and cathode word build.
module ntsd_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  ntsd_pkg::in_item_t s_data,
    output logic              word_valid,
    input  logic              word_ready,
    output ntsd_pkg::word_t   word_data
);
    import ntsd_pkg::*;

    logic        time_format_reg;
    logic        time_format_next;
    logic        valid_reg;
    logic        valid_next;
    word_t       word_reg;
    word_t       word_next;
    logic        s_accept;
    logic [4:0]  hour_shown;
    digit_pair_t hour_d;
    digit_pair_t min_d;
    digit_pair_t sec_d;
    digit_t      digits [TUBE_COUNT];
    logic        dots;
    word_t       built;

    assign cfg_ready = 1'b1;
    assign s_ready   = !valid_reg || word_ready;
    assign s_accept  = s_valid && s_ready;

    assign word_valid = valid_reg;
    assign word_data  = word_reg;

    always_comb begin
        hour_shown = (time_format_reg == FMT_12H) ? hour_12(s_data.hour_value)
                                                  : s_data.hour_value;
        hour_d = split_digits({1'b0, hour_shown});
        min_d  = split_digits(s_data.minute_value);
        sec_d  = split_digits(s_data.second_value);
        if (s_data.req_type == REQ_TIME) begin
            digits[0] = hour_d.tens;
            digits[1] = hour_d.units;
            digits[2] = min_d.tens;
            digits[3] = min_d.units;
            digits[4] = sec_d.tens;
            digits[5] = sec_d.units;
            dots      = !s_data.second_value[0];
        end else begin
            digits[0] = s_data.digit_hour_tens;
            digits[1] = s_data.digit_hour_units;
            digits[2] = s_data.digit_minute_tens;
            digits[3] = s_data.digit_minute_units;
            digits[4] = s_data.digit_second_tens;
            digits[5] = s_data.digit_second_units;
            dots      = s_data.dots_on;
        end
        built = '0;
        for (int t = 0; t < TUBE_COUNT; t++) begin
            built = built | digit_mask(3'(t), digits[t]);
        end
        if (dots) begin
            for (int k = 0; k < DOT_COUNT; k++) begin
                built[DOT_BITS[k]] = 1'b1;
            end
        end
    end

    always_comb begin
        time_format_next = (cfg_valid && cfg_ready) ? cfg_data : time_format_reg;
        valid_next       = s_accept || (valid_reg && !word_ready);
        word_next        = s_accept ? built : word_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_format_reg <= FMT_24H;
            valid_reg       <= 1'b0;
        end else begin
            time_format_reg <= time_format_next;
            valid_reg       <= valid_next;
        end
        word_reg <= word_next;
    end

endmodule

// File: hdl/ntsd_queue.sv
// Small word queue between the front end and the serializer.
module ntsd_queue #(
    parameter int DEPTH = ntsd_pkg::QUEUE_DEPTH_DEF,
    parameter int WIDTH = ntsd_pkg::WORD_BITS
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    import ntsd_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hdl/ntsd_shift.sv
// Back end: shifts each cathode word out MSB first, marks the last bit.
module ntsd_shift (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               word_valid,
    output logic               word_ready,
    input  ntsd_pkg::word_t    word_data,
    output logic               m_valid,
    input  logic               m_ready,
    output ntsd_pkg::out_item_t m_data
);
    import ntsd_pkg::*;

    word_t    shift_reg;
    word_t    shift_next;
    bit_idx_t cnt_reg;
    bit_idx_t cnt_next;
    logic     busy_reg;
    logic     busy_next;
    logic     at_last;
    logic     load;

    assign at_last    = cnt_reg == BIT_IDX_MAX;
    assign word_ready = !busy_reg || (m_ready && at_last);
    assign load       = word_valid && word_ready;

    assign m_valid           = busy_reg;
    assign m_data.serial_bit = shift_reg[WORD_BITS-1];
    assign m_data.last_bit   = at_last;

    always_comb begin
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        if (load) begin
            shift_next = word_data;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end else if (busy_reg && m_ready) begin
            if (at_last) begin
                busy_next = 1'b0;
            end else begin
                shift_next = {shift_reg[WORD_BITS-2:0], 1'b0};
                cnt_next   = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        shift_reg <= shift_next;
    end

endmodule

// File: hdl/nixie_tube_shift_driver.sv
// Top level of the nixie tube shift driver.
// Each accepted input transaction builds one 64-bit cathode word for six tubes
// (hour, minute, second tens/units) and produces 64 output transactions, word
// bit 63 first, with last_bit set on the 64th so the latch can pulse after it.
// Time mode (req_type 0) splits hour/minute/second into digits and lights the
// dots on even seconds; with time_format 0 the hour shows in 12-hour form (0
// as 12). Raw mode (req_type 1) takes six digits and dots_on directly; a digit
// of 10..15 blanks its tube. time_format resets to 1 (24-hour) and is written
// through the cfg channel, which is always ready; write it only when idle.
// Rate: the serial output gives one bit per cycle while m_ready is high.
// Words of consecutive items follow with no gap cycles: while a word shifts
// out, the next item is decoded and held in a queue of QUEUE_DEPTH words. The
// first bit of an item is offered once its word has passed the front-end register
// and the queue and has loaded into the shift register. No clearing pass after reset.
module nixie_tube_shift_driver #(
    parameter int QUEUE_DEPTH = ntsd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // register write channel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data,
    // input items
    input  logic                s_valid,
    output logic                s_ready,
    input  ntsd_pkg::in_item_t  s_data,
    // serial bits
    output logic                m_valid,
    input  logic                m_ready,
    output ntsd_pkg::out_item_t m_data
);
    import ntsd_pkg::*;

    // front end -> queue
    logic  fw_valid;
    logic  fw_ready;
    word_t fw_data;
    // queue -> serializer
    logic  bw_valid;
    logic  bw_ready;
    word_t bw_data;

    // Decode and word build, one registered stage.
    ntsd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .word_valid (fw_valid),
        .word_ready (fw_ready),
        .word_data  (fw_data)
    );

    // Decouples the decode from the bit-serial shift-out.
    ntsd_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (WORD_BITS)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fw_valid),
        .push_ready (fw_ready),
        .push_data  (fw_data),
        .pop_valid  (bw_valid),
        .pop_ready  (bw_ready),
        .pop_data   (bw_data)
    );

    // Shift register drives the output directly; next word loads on the
    // same edge the last bit is taken.
    ntsd_shift u_shift (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .word_valid (bw_valid),
        .word_ready (bw_ready),
        .word_data  (bw_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

// File: hdl/ntsd_checker.sv
// Port-level checker for the nixie tube shift driver, bound to the top level.
`include "nixie_tube_shift_driver_assert.svh"

module ntsd_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                cfg_ready,
    input logic                s_valid,
    input logic                s_ready,
    input ntsd_pkg::in_item_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input ntsd_pkg::out_item_t m_data
);
    import ntsd_pkg::*;

    // Position of the next output bit within its word.
    bit_idx_t pos_reg;
    bit_idx_t pos_next;

    assign pos_next = (m_valid && m_ready) ? pos_reg + 1'b1 : pos_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

    `NTSD_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_valid)
    `NTSD_ASSERT(a_last_framing, aclk, aresetn,
        m_valid |-> (m_data.last_bit == (pos_reg == BIT_IDX_MAX)))
    `NTSD_ASSERT(a_out_hold, aclk, aresetn,
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
    `NTSD_ASSERT(a_in_hold, aclk, aresetn,
        (s_valid && !s_ready) |=> (s_valid && $stable(s_data)))
    `NTSD_ASSERT(a_cfg_ready, aclk, aresetn, cfg_ready)

endmodule

bind nixie_tube_shift_driver ntsd_checker u_ntsd_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_ready (cfg_ready),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_data    (s_data),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data)
);
